@@ rtl/time_slice_priority_scheduler_assert.svh @@
// ----------------------------------------------------------------------------
// time slice priority scheduler assertion macros
// concurrent property helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef TIME_SLICE_PRIORITY_SCHEDULER_ASSERT_SVH
`define TIME_SLICE_PRIORITY_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TSPS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TSPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tsps_pkg.sv @@
// ----------------------------------------------------------------------------
// tsps_pkg
// shared constants, control word types and microprogram of the scheduler
// ----------------------------------------------------------------------------
package tsps_pkg;

  // task set and field widths
  localparam int TASK_COUNT = 8;
  localparam int TASK_W     = (TASK_COUNT > 2) ? $clog2(TASK_COUNT) : 1;
  localparam int SLICE_W    = 5;
  localparam int PRIO_W     = 4;
  localparam int RUN_W      = 3;
  localparam int PRIO_REG_W = 32;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 4;

  localparam logic [SLICE_W-1:0]    SLICE_MAX     = SLICE_W'(31);
  localparam logic [PRIO_REG_W-1:0] PRIO_RESET    = 32'h1111_1110;
  localparam logic [MASK_W-1:0]     MASK_RESET    = 8'hFE;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITIES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RUNNABLE   = CFG_IDX_W'(1);

  typedef logic [STEP_W-1:0] step_t;

  // microprogram step addresses
  localparam step_t ST_WAIT  = STEP_W'(0);
  localparam step_t ST_TICK  = STEP_W'(1);
  localparam step_t ST_IDLE  = STEP_W'(2);
  localparam step_t ST_DEC   = STEP_W'(3);
  localparam step_t ST_PINIT = STEP_W'(4);
  localparam step_t ST_PSCAN = STEP_W'(5);
  localparam step_t ST_PCHK  = STEP_W'(6);
  localparam step_t ST_RINIT = STEP_W'(7);
  localparam step_t ST_RFILL = STEP_W'(8);
  localparam step_t ST_RJMP  = STEP_W'(9);
  localparam step_t ST_DONE  = STEP_W'(10);

  typedef enum logic [0:0] {
    RD_CUR = 1'b0,
    RD_IDX = 1'b1
  } rd_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_TOP  = 3'd1,
    IDX_ONE  = 3'd2,
    IDX_DEC  = 3'd3,
    IDX_INC  = 3'd4
  } idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_DEC  = 2'd1,
    WR_FILL = 2'd2
  } wr_op_t;

  typedef enum logic [3:0] {
    C_NEXT      = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_START  = 4'd2,
    C_NO_TICK   = 4'd3,
    C_CUR_IDLE  = 4'd4,
    C_DEC_NZ    = 4'd5,
    C_SCAN_MORE = 4'd6,
    C_FILL_MORE = 4'd7,
    C_PICK_END  = 4'd8
  } cond_t;

  // datapath part of a control word
  typedef struct packed {
    rd_sel_t rd_sel;
    idx_op_t idx_op;
    logic    best_clr;
    logic    best_upd;
    wr_op_t  wr_op;
    logic    cur_load;
    logic    set_refill;
    logic    latch;
    logic    out_load;
  } ctl_t;

  // full control word: datapath controls plus jump
  typedef struct packed {
    ctl_t  ctl;
    cond_t cond;
    step_t target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic tick;
    logic cur_idle;
    logic dec_nz;
    logic scan_more;
    logic fill_more;
    logic pick_end;
  } stat_t;

  localparam ctl_t CTL_NOP = '{
    rd_sel:     RD_CUR,
    idx_op:     IDX_HOLD,
    best_clr:   1'b0,
    best_upd:   1'b0,
    wr_op:      WR_NONE,
    cur_load:   1'b0,
    set_refill: 1'b0,
    latch:      1'b0,
    out_load:   1'b0
  };

  // microprogram rom
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    w.ctl    = CTL_NOP;
    w.cond   = C_NEXT;
    w.target = ST_WAIT;
    unique case (step)
      ST_WAIT: begin
        w.ctl.latch = 1'b1;
        w.cond      = C_NO_START;
        w.target    = ST_WAIT;
      end
      ST_TICK: begin
        w.cond   = C_NO_TICK;
        w.target = ST_DONE;
      end
      ST_IDLE: begin
        w.ctl.rd_sel = RD_CUR;
        w.cond       = C_CUR_IDLE;
        w.target     = ST_PINIT;
      end
      ST_DEC: begin
        w.ctl.rd_sel = RD_CUR;
        w.ctl.wr_op  = WR_DEC;
        w.cond       = C_DEC_NZ;
        w.target     = ST_DONE;
      end
      ST_PINIT: begin
        w.ctl.idx_op   = IDX_TOP;
        w.ctl.best_clr = 1'b1;
      end
      ST_PSCAN: begin
        w.ctl.rd_sel   = RD_IDX;
        w.ctl.best_upd = 1'b1;
        w.ctl.idx_op   = IDX_DEC;
        w.cond         = C_SCAN_MORE;
        w.target       = ST_PSCAN;
      end
      ST_PCHK: begin
        w.ctl.cur_load = 1'b1;
        w.cond         = C_PICK_END;
        w.target       = ST_DONE;
      end
      ST_RINIT: begin
        w.ctl.idx_op     = IDX_ONE;
        w.ctl.set_refill = 1'b1;
      end
      ST_RFILL: begin
        w.ctl.rd_sel = RD_IDX;
        w.ctl.wr_op  = WR_FILL;
        w.ctl.idx_op = IDX_INC;
        w.cond       = C_FILL_MORE;
        w.target     = ST_RFILL;
      end
      ST_RJMP: begin
        w.cond   = C_ALWAYS;
        w.target = ST_PINIT;
      end
      ST_DONE: begin
        w.ctl.rd_sel   = RD_CUR;
        w.ctl.out_load = 1'b1;
        w.cond         = C_ALWAYS;
        w.target       = ST_WAIT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/tsps_sequencer.sv @@
// ----------------------------------------------------------------------------
// tsps_sequencer
// step counter over the microprogram rom with conditional jumps
// ----------------------------------------------------------------------------
module tsps_sequencer import tsps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  busy
);

  step_t  pc;
  step_t  pc_next;
  uword_t word;
  logic   take;

  // fetch the control word of this step
  assign word = ucode_rom(pc);
  assign busy = (pc != ST_WAIT);

  // latch only fires on an accepted beat
  always_comb begin
    ctl       = word.ctl;
    ctl.latch = word.ctl.latch & start;
  end

  // jump condition select
  always_comb begin
    unique case (word.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_START:  take = ~start;
      C_NO_TICK:   take = ~stat.tick;
      C_CUR_IDLE:  take = stat.cur_idle;
      C_DEC_NZ:    take = stat.dec_nz;
      C_SCAN_MORE: take = stat.scan_more;
      C_FILL_MORE: take = stat.fill_more;
      C_PICK_END:  take = stat.pick_end;
      default:     take = 1'b1;
    endcase
  end

  assign pc_next = take ? word.target : pc + STEP_W'(1);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/tsps_datapath.sv @@
// ----------------------------------------------------------------------------
// tsps_datapath
// slice table, scan registers, configuration registers and result registers
// ----------------------------------------------------------------------------
module tsps_datapath import tsps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  logic                  tick,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output stat_t                 stat,
  output logic                  done,
  output logic [RUN_W-1:0]      running_task,
  output logic                  switched,
  output logic                  refilled,
  output logic [SLICE_W-1:0]    slice_left,
  output logic                  no_runnable
);

  logic [PRIO_REG_W-1:0] priorities;
  logic [MASK_W-1:0]     runnable_mask;
  logic [SLICE_W-1:0]    slice_table [TASK_COUNT];
  logic [TASK_W-1:0]     cur;
  logic [TASK_W-1:0]     prev;
  logic [TASK_W-1:0]     idx;
  logic [TASK_W-1:0]     best;
  logic [SLICE_W-1:0]    best_slice;
  logic                  tick_r;
  logic                  refill_flag;
  logic                  none_flag;

  logic [TASK_W-1:0]     addr;
  logic [SLICE_W-1:0]    rd;
  logic [SLICE_W-1:0]    dec_val;
  logic [PRIO_REG_W-1:0] prio_sh;
  logic [MASK_W-1:0]     mask_sh;
  logic [PRIO_W-1:0]     prio_idx;
  logic                  run_idx;
  logic [SLICE_W:0]      fill_sum;
  logic [SLICE_W-1:0]    fill_val;

  // one shared table read port
  assign addr = (ctl.rd_sel == RD_IDX) ? idx : cur;
  assign rd   = slice_table[addr];

  // saturating decrement of the running slice
  assign dec_val = (rd == '0) ? '0 : rd - SLICE_W'(1);

  // priority and runnable bit of the scanned task; tasks past the registers read zero
  assign prio_sh  = priorities >> {idx, 2'b00};
  assign mask_sh  = runnable_mask >> idx;
  assign prio_idx = prio_sh[PRIO_W-1:0];
  assign run_idx  = (idx != '0) && mask_sh[0];

  // refill: half the old slice plus priority, saturated
  assign fill_sum = (SLICE_W+1)'(rd >> 1) + (SLICE_W+1)'(prio_idx);
  assign fill_val = (fill_sum > (SLICE_W+1)'(SLICE_MAX)) ? SLICE_MAX
                                                         : fill_sum[SLICE_W-1:0];

  // status to the sequencer
  always_comb begin
    stat.tick      = tick_r;
    stat.cur_idle  = (cur == '0);
    stat.dec_nz    = (dec_val != '0);
    stat.scan_more = (idx != TASK_W'(1));
    stat.fill_more = (idx != TASK_W'(TASK_COUNT - 1));
    stat.pick_end  = (best != '0) || refill_flag;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      priorities    <= PRIO_RESET;
      runnable_mask <= MASK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRIORITIES: priorities    <= cfg_data;
        REG_RUNNABLE:   runnable_mask <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // slice table write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        slice_table[i] <= '0;
      end
    end else begin
      unique case (ctl.wr_op)
        WR_DEC:  slice_table[addr] <= dec_val;
        WR_FILL: slice_table[addr] <= fill_val;
        default: ;
      endcase
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    unique case (ctl.idx_op)
      IDX_TOP: idx <= TASK_W'(TASK_COUNT - 1);
      IDX_ONE: idx <= TASK_W'(1);
      IDX_DEC: idx <= idx - TASK_W'(1);
      IDX_INC: idx <= idx + TASK_W'(1);
      default: ;
    endcase
  end

  // best candidate; the scan runs from the top so a tie keeps the higher index
  always_ff @(posedge clk) begin
    if (ctl.best_clr) begin
      best       <= '0;
      best_slice <= '0;
    end else if (ctl.best_upd && run_idx && (rd > best_slice)) begin
      best       <= idx;
      best_slice <= rd;
    end
  end

  // running task and per-beat flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cur         <= '0;
      prev        <= '0;
      tick_r      <= 1'b0;
      refill_flag <= 1'b0;
      none_flag   <= 1'b0;
    end else begin
      if (ctl.latch) begin
        prev        <= cur;
        tick_r      <= tick;
        refill_flag <= 1'b0;
        none_flag   <= 1'b0;
      end
      if (ctl.set_refill) begin
        refill_flag <= 1'b1;
      end
      if (ctl.cur_load) begin
        cur       <= best;
        none_flag <= (best == '0) && refill_flag;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.out_load;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      running_task <= RUN_W'(cur);
      switched     <= (cur != prev);
      refilled     <= refill_flag;
      slice_left   <= (cur == '0) ? '0 : rd;
      no_runnable  <= none_flag;
    end
  end

endmodule

@@ rtl/time_slice_priority_scheduler.sv @@
// Accept to result beat: a status beat (tick low) goes straight to the result; a tick that
// keeps the task running decrements its slice; a pick scans the table; a refill then rescans.
// Throughput: one beat at a time; the next start is taken in the cycle the result shows.
// The microprogram walks the slice table one task per cycle in its scan and refill loops.
// Reset: synchronous; all slices zero, idle task running, registers at their defaults.
// ----------------------------------------------------------------------------
// time_slice_priority_scheduler
// counter/priority task scheduler driven by a microcoded sequencer
// ----------------------------------------------------------------------------
module time_slice_priority_scheduler import tsps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  tick,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [RUN_W-1:0]      running_task,
  output logic                  switched,
  output logic                  refilled,
  output logic [SLICE_W-1:0]    slice_left,
  output logic                  no_runnable
);

  ctl_t  ctl;
  stat_t stat;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // control sequencer
  tsps_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // datapath
  tsps_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .tick         (tick),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .done         (done),
    .running_task (running_task),
    .switched     (switched),
    .refilled     (refilled),
    .slice_left   (slice_left),
    .no_runnable  (no_runnable)
  );

endmodule

@@ rtl/tsps_checker.sv @@
// ----------------------------------------------------------------------------
// tsps_checker
// port-level checks on the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "time_slice_priority_scheduler_assert.svh"

module tsps_checker import tsps_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [RUN_W-1:0]   running_task,
  input logic               refilled,
  input logic [SLICE_W-1:0] slice_left,
  input logic               no_runnable
);

  // a result beat only shows once the sequencer is back to waiting
  `TSPS_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result while busy")

  // an accepted beat makes the block busy
  `TSPS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept without busy")

  // the result strobe lasts one cycle
  `TSPS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe held")

  // idle task reports no slice
  `TSPS_ASSERT_SAME(a_idle_slice, clk, rst, done && (running_task == '0),
    slice_left == '0, "idle task with slice")

  // nothing runnable only after a refill, and then idle runs
  `TSPS_ASSERT_SAME(a_none_refill, clk, rst, done && no_runnable,
    refilled && (running_task == '0), "no runnable without refill")

endmodule

bind time_slice_priority_scheduler tsps_checker u_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// time slice priority scheduler testbench
// drives tick and status beats in random bursts, rewrites the priority and
// runnable registers between phases, and checks every result strobe against
// a cycle-free model of the counter/priority scheduler
// ----------------------------------------------------------------------------
module testbench import tsps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [RUN_W-1:0]   run_id;
    logic               sw;
    logic               refill;
    logic [SLICE_W-1:0] slice;
    logic               none;
  } sched_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  tick = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PRIORITIES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic [RUN_W-1:0]      running_task;
  logic                  switched;
  logic                  refilled;
  logic [SLICE_W-1:0]    slice_left;
  logic                  no_runnable;

  // scheduler model state and register copies
  logic [SLICE_W-1:0]    slices [TASK_COUNT];
  logic [RUN_W-1:0]      cur_task;
  logic [PRIO_REG_W-1:0] prio_reg;
  logic [MASK_W-1:0]     run_reg;

  logic                  pending_ticks [$];
  sched_result_t         expected_results [$];
  int                    gap_left = 0;
  int                    burst_left = 0;
  int                    mismatches = 0;
  int                    quiet_cycles = 0;

  time_slice_priority_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .tick         (tick),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .running_task (running_task),
    .switched     (switched),
    .refilled     (refilled),
    .slice_left   (slice_left),
    .no_runnable  (no_runnable)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // runnable task with the largest nonzero slice, highest index on a tie
  function automatic logic [RUN_W-1:0] pick_task();
    logic [RUN_W-1:0]   best;
    logic [SLICE_W-1:0] best_slice;
    best = '0;
    best_slice = '0;
    for (int i = TASK_COUNT - 1; i >= 1; i--) begin
      if (run_reg[i] && slices[i] > best_slice) begin
        best_slice = slices[i];
        best = RUN_W'(i);
      end
    end
    return best;
  endfunction

  // advance the scheduler model by one beat and queue its result
  task automatic schedule_beat(input logic tk);
    sched_result_t    r;
    logic [RUN_W-1:0] prev;
    logic [RUN_W-1:0] nxt;
    logic             go;
    logic [5:0]       v;
    prev = cur_task;
    r = '0;
    go = 1'b0;
    if (tk) begin
      if (cur_task == '0) begin
        go = 1'b1;
      end else begin
        if (slices[cur_task] != '0) slices[cur_task] = slices[cur_task] - 1'b1;
        if (slices[cur_task] == '0) go = 1'b1;
      end
      if (go) begin
        nxt = pick_task();
        if (nxt == '0) begin
          // refill: half the old slice plus priority, saturated
          for (int i = 1; i < TASK_COUNT; i++) begin
            v = 6'(slices[i] >> 1) + 6'(prio_reg[PRIO_W*i +: PRIO_W]);
            slices[i] = (v > 6'(SLICE_MAX)) ? SLICE_MAX : v[SLICE_W-1:0];
          end
          r.refill = 1'b1;
          nxt = pick_task();
          if (nxt == '0) r.none = 1'b1;
        end
        cur_task = nxt;
      end
    end
    r.run_id = cur_task;
    r.sw     = (cur_task != prev);
    r.slice  = (cur_task == '0) ? '0 : slices[cur_task];
    expected_results.push_back(r);
  endtask

  task automatic flag_mismatch(input string field, input int expv, input int gotv);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, expv, gotv);
  endtask

  // beat driver: bursts of items with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) schedule_beat(tick);
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          tick     <= 1'($urandom_range(0, 1));
          gap_left <= gap_left - 1;
        end else if (pending_ticks.size() != 0) begin
          start <= 1'b1;
          tick  <= pending_ticks.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 3);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result, running_task", -1, running_task);
      end else begin
        e = expected_results.pop_front();
        if (running_task !== e.run_id) flag_mismatch("running_task", e.run_id, running_task);
        if (switched !== e.sw) flag_mismatch("switched", e.sw, switched);
        if (refilled !== e.refill) flag_mismatch("refilled", e.refill, refilled);
        if (slice_left !== e.slice) flag_mismatch("slice_left", e.slice, slice_left);
        if (no_runnable !== e.none) flag_mismatch("no_runnable", e.none, no_runnable);
      end
    end
  end

  // watchdog on cycles with no accepted beat of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** time_slice_priority_scheduler: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register write, called at a rising edge, returns at a rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_PRIORITIES) prio_reg = data[PRIO_REG_W-1:0];
    else run_reg = data[MASK_W-1:0];
    @(posedge clk);
  endtask

  // wait until every queued beat is taken and answered; sampled mid-cycle
  task automatic wait_drained();
    @(negedge clk);
    while (pending_ticks.size() != 0 || start || busy || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // directed beats, lsb first
  task automatic run_pattern(input logic [31:0] bits, input int count);
    @(negedge clk);
    for (int i = 0; i < count; i++) pending_ticks.push_back(bits[i]);
    wait_drained();
  endtask

  task automatic run_random(input int count, input int tick_pct);
    @(negedge clk);
    repeat (count) pending_ticks.push_back($urandom_range(0, 99) < tick_pct);
    wait_drained();
  endtask

  initial begin
    logic [PRIO_REG_W-1:0] prio;
    logic [CFG_DATA_W-1:0] word;
    logic [MASK_W-1:0]     mask;
    prio_reg = PRIO_RESET;
    run_reg  = MASK_RESET;
    cur_task = '0;
    for (int i = 0; i < TASK_COUNT; i++) slices[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: status beats, idle schedule with refill, slices running out
    run_pattern(32'b1111_0110, 8);
    // nothing runnable: refill then fall back to idle
    write_reg(REG_RUNNABLE, 32'h0000_0000);
    run_pattern(32'b111, 3);
    // largest priorities, ignored bit 0 of the mask set
    write_reg(REG_PRIORITIES, 32'hFFFF_FFFF);
    write_reg(REG_RUNNABLE, 32'hFFFF_FFFF);
    run_pattern(32'b11_1111, 6);
    // zero priorities, only the top task runnable
    write_reg(REG_PRIORITIES, 32'h0000_0000);
    write_reg(REG_RUNNABLE, 32'h0000_0081);
    run_pattern(32'b1101, 4);

    // random phases with fresh register settings
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: prio = $urandom();
        1: prio = ($urandom_range(0, 1) != 0) ? '1 : '0;
        default: begin
          for (int i = 0; i < TASK_COUNT; i++)
            prio[PRIO_W*i +: PRIO_W] = PRIO_W'($urandom_range(0, 3));
        end
      endcase
      case ($urandom_range(0, 7))
        0: mask = '0;
        1: mask = '1;
        2: mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        default: mask = MASK_W'($urandom_range(0, 255));
      endcase
      word = $urandom();
      word[MASK_W-1:0] = mask;
      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_PRIORITIES, prio);
        write_reg(REG_RUNNABLE, word);
      end else begin
        write_reg(REG_RUNNABLE, word);
        write_reg(REG_PRIORITIES, prio);
      end
      run_random(48, 90);
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("** time_slice_priority_scheduler: PASSED **");
    end else begin
      $display("** time_slice_priority_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
